// ----- rtl/core/conveyor_inspection_sequencer_assert.svh -----
// Assertion macros shared by the sequencer RTL.
`ifndef CONVEYOR_INSPECTION_SEQUENCER_ASSERT_SVH
`define CONVEYOR_INSPECTION_SEQUENCER_ASSERT_SVH

// Property checked on every clock edge outside reset.
`define CIS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define CIS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/cis_pkg.sv -----
`default_nettype none

package cis_pkg;

  localparam int CFG_W = 16;
  localparam int CFG_IDX_W = 2;
  localparam int TICK_WIDTH_DEF = 16;
  localparam int SCORE_WIDTH_DEF = 16;
  localparam int CNT_W = 3;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_APPROACH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd3;

  localparam logic [CFG_W-1:0] APPROACH_RST  = 16'd200;
  localparam logic [CFG_W-1:0] RELEASE_RST   = 16'd1500;
  localparam logic [CFG_W-1:0] TIMEOUT_RST   = 16'd4000;
  // 5.5 in Q8.8.
  localparam logic [CFG_W-1:0] THRESHOLD_RST = 16'd1408;

  // Score counter: first score is discarded, the fourth completes the median.
  localparam logic [CNT_W-1:0] CNT_FIRST_KEPT = 3'd2;
  localparam logic [CNT_W-1:0] CNT_MEDIAN     = 3'd4;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_APPROACH = 3'd1,
    PH_INSPECT  = 3'd2,
    PH_RELEASE  = 3'd3,
    PH_COOLDOWN = 3'd4
  } phase_e;

  typedef struct packed {
    logic [CFG_W-1:0] approach_ticks;
    logic [CFG_W-1:0] release_ticks;
    logic [CFG_W-1:0] timeout_ticks;
    logic [CFG_W-1:0] threshold;
  } cis_cfg_t;

  typedef struct packed {
    logic part_present;
    logic score_valid;
  } cis_tick_t;

  typedef struct packed {
    phase_e phase;
    logic   belt_running;
    logic   reject_arm_out;
    logic   decision_valid;
    logic   part_bad;
    logic   timed_out;
  } cis_status_t;

endpackage

`default_nettype wire

// ----- rtl/core/cis_cfg.sv -----
`default_nettype none

module cis_cfg import cis_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 we_i,
  input  wire logic [CFG_IDX_W-1:0] idx_i,
  input  wire logic [CFG_W-1:0]     wdata_i,
  output cis_cfg_t                  cfg_o
);

  cis_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      case (idx_i)
        CFG_APPROACH:  cfg_d.approach_ticks = wdata_i;
        CFG_RELEASE:   cfg_d.release_ticks  = wdata_i;
        CFG_TIMEOUT:   cfg_d.timeout_ticks  = wdata_i;
        CFG_THRESHOLD: cfg_d.threshold      = wdata_i;
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.approach_ticks <= APPROACH_RST;
      cfg_q.release_ticks  <= RELEASE_RST;
      cfg_q.timeout_ticks  <= TIMEOUT_RST;
      cfg_q.threshold      <= THRESHOLD_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ----- rtl/core/cis_in_reg.sv -----
`default_nettype none

module cis_in_reg import cis_pkg::*; #(
  parameter int SCORE_WIDTH = SCORE_WIDTH_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   valid_i,
  output logic                        ready_o,
  input  wire cis_tick_t              tick_i,
  input  wire logic [SCORE_WIDTH-1:0] score_i,
  input  wire logic                   adv_i,
  output logic                        valid_o,
  output cis_tick_t                   tick_o,
  output logic [SCORE_WIDTH-1:0]      score_o
);

  logic                   valid_q, valid_d;
  logic                   load;
  cis_tick_t              tick_q;
  logic [SCORE_WIDTH-1:0] score_q;

  // The slot frees up in the same cycle its request moves on.
  assign ready_o = !valid_q || adv_i;
  assign load    = valid_i && ready_o;
  assign valid_d = load || (valid_q && !adv_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      tick_q  <= tick_i;
      score_q <= score_i;
    end
  end

  assign valid_o = valid_q;
  assign tick_o  = tick_q;
  assign score_o = score_q;

endmodule

`default_nettype wire

// ----- rtl/core/cis_seq.sv -----
`default_nettype none

module cis_seq import cis_pkg::*; #(
  parameter int TICK_WIDTH  = TICK_WIDTH_DEF,
  parameter int SCORE_WIDTH = SCORE_WIDTH_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   adv_i,
  input  wire cis_cfg_t               cfg_i,
  input  wire cis_tick_t              tick_i,
  input  wire logic [SCORE_WIDTH-1:0] score_i,
  output cis_status_t                 status_o,
  output logic [SCORE_WIDTH-1:0]      median_o
);

  localparam int CMP_W = (TICK_WIDTH > CFG_W) ? TICK_WIDTH : CFG_W;
  localparam logic [TICK_WIDTH-1:0] TICK_MAX = {TICK_WIDTH{1'b1}};

  phase_e                 phase_q, phase_d;
  logic [TICK_WIDTH-1:0]  elapsed_q, elapsed_d, elapsed_inc;
  logic [CNT_W-1:0]       cnt_q, cnt_d, cnt_inc;
  logic                   bad_q, bad_d;
  logic                   belt_q, belt_d;
  logic                   arm_q, arm_d;
  // Only the second and third scores are kept; the fourth comes straight from the input.
  logic [SCORE_WIDTH-1:0] slot_q [2];

  logic                   approach_done, timeout_hit, release_done;
  logic                   score_take, median_hit, slot_we;
  logic [SCORE_WIDTH-1:0] lo_ab, hi_ab, hi_c, med, thr;
  logic                   med_bad;
  logic                   dec, part_bad, tmo;
  logic [SCORE_WIDTH-1:0] med_out;

  assign elapsed_inc = (phase_q != PH_IDLE && elapsed_q != TICK_MAX) ?
                       elapsed_q + 1'b1 : elapsed_q;

  assign approach_done = CMP_W'(elapsed_inc) >= CMP_W'(cfg_i.approach_ticks);
  assign timeout_hit   = CMP_W'(elapsed_inc) >  CMP_W'(cfg_i.timeout_ticks);
  assign release_done  = CMP_W'(elapsed_inc) >= CMP_W'(cfg_i.release_ticks);

  // A timeout on the same tick wins over an arriving score.
  assign score_take = (phase_q == PH_INSPECT) && !timeout_hit && tick_i.score_valid;
  assign cnt_inc    = (cnt_q < CNT_MEDIAN) ? cnt_q + 1'b1 : cnt_q;
  assign median_hit = score_take && (cnt_inc >= CNT_MEDIAN);
  assign slot_we    = score_take && (cnt_inc >= CNT_FIRST_KEPT) && (cnt_inc < CNT_MEDIAN);

  assign lo_ab   = (slot_q[0] < slot_q[1]) ? slot_q[0] : slot_q[1];
  assign hi_ab   = (slot_q[0] > slot_q[1]) ? slot_q[0] : slot_q[1];
  assign hi_c    = (hi_ab < score_i) ? hi_ab : score_i;
  assign med     = (lo_ab > hi_c) ? lo_ab : hi_c;
  assign thr     = SCORE_WIDTH'(cfg_i.threshold);
  assign med_bad = med >= thr;

  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      PH_IDLE: begin
        if (tick_i.part_present) phase_d = PH_APPROACH;
      end
      PH_APPROACH: begin
        if (approach_done) phase_d = PH_INSPECT;
      end
      PH_INSPECT: begin
        if (timeout_hit || median_hit) phase_d = PH_RELEASE;
      end
      PH_RELEASE: begin
        if (release_done) phase_d = PH_COOLDOWN;
      end
      PH_COOLDOWN: begin
        if (!tick_i.part_present) phase_d = PH_IDLE;
      end
      default: phase_d = PH_IDLE;
    endcase
  end

  // Every phase change restarts the tick count.
  assign elapsed_d = (phase_d != phase_q) ? '0 : elapsed_inc;

  always_comb begin
    belt_d   = belt_q;
    arm_d    = arm_q;
    bad_d    = bad_q;
    cnt_d    = cnt_q;
    dec      = 1'b0;
    part_bad = 1'b0;
    tmo      = 1'b0;
    med_out  = '0;
    case (phase_q)
      PH_APPROACH: begin
        if (approach_done) begin
          belt_d = 1'b0;
          cnt_d  = '0;
        end
      end
      PH_INSPECT: begin
        if (timeout_hit) begin
          bad_d  = 1'b0;
          belt_d = 1'b1;
          dec    = 1'b1;
          tmo    = 1'b1;
        end else if (tick_i.score_valid) begin
          cnt_d = cnt_inc;
          if (median_hit) begin
            bad_d    = med_bad;
            arm_d    = arm_q || med_bad;
            belt_d   = 1'b1;
            dec      = 1'b1;
            part_bad = med_bad;
            med_out  = med;
          end
        end
      end
      PH_RELEASE: begin
        if (release_done && bad_q) arm_d = 1'b0;
      end
      default: begin
        belt_d = belt_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      elapsed_q <= '0;
      cnt_q     <= '0;
      bad_q     <= 1'b0;
      belt_q    <= 1'b1;
      arm_q     <= 1'b0;
    end else if (adv_i) begin
      phase_q   <= phase_d;
      elapsed_q <= elapsed_d;
      cnt_q     <= cnt_d;
      bad_q     <= bad_d;
      belt_q    <= belt_d;
      arm_q     <= arm_d;
    end
  end

  // Second score lands in slot 0, third in slot 1.
  always_ff @(posedge clk_i) begin
    if (adv_i && slot_we) begin
      slot_q[cnt_inc[0]] <= score_i;
    end
  end

  assign status_o.phase          = phase_d;
  assign status_o.belt_running   = belt_d;
  assign status_o.reject_arm_out = arm_d;
  assign status_o.decision_valid = dec;
  assign status_o.part_bad       = part_bad;
  assign status_o.timed_out      = tmo;
  assign median_o                = med_out;

`include "conveyor_inspection_sequencer_assert.svh"

  `CIS_ASSERT(a_arm_only_in_release, clk_i, rst_ni, arm_q |-> (phase_q == PH_RELEASE && bad_q), "reject arm out outside a bad release")
  `CIS_ASSERT(a_belt_stop_inspect, clk_i, rst_ni, !belt_q |-> (phase_q == PH_INSPECT), "belt stopped outside inspection")
  `CIS_ASSERT_NEXT(a_hold_on_stall, clk_i, rst_ni, !adv_i, $stable(phase_q) && $stable(elapsed_q), "sequencer state moved without a request")
  `CIS_ASSERT_NEXT(a_decision_release, clk_i, rst_ni, adv_i && phase_q == PH_INSPECT && (timeout_hit || median_hit), phase_q == PH_RELEASE && belt_q && elapsed_q == '0, "decision did not restart the belt in release")

endmodule

`default_nettype wire

// ----- rtl/core/cis_out_reg.sv -----
`default_nettype none

module cis_out_reg import cis_pkg::*; #(
  parameter int SCORE_WIDTH = SCORE_WIDTH_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   load_i,
  input  wire cis_status_t            status_i,
  input  wire logic [SCORE_WIDTH-1:0] median_i,
  input  wire logic                   ready_i,
  output logic                        valid_o,
  output cis_status_t                 status_o,
  output logic [SCORE_WIDTH-1:0]      median_o
);

  logic                   valid_q, valid_d;
  cis_status_t            status_q;
  logic [SCORE_WIDTH-1:0] median_q;

  assign valid_d = load_i || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      status_q <= status_i;
      median_q <= median_i;
    end
  end

  assign valid_o  = valid_q;
  assign status_o = status_q;
  assign median_o = median_q;

endmodule

`default_nettype wire

// ----- rtl/core/conveyor_inspection_sequencer.sv -----
// Channel   Direction  Handshake                  Payload
// cfg       in         cfg_we_i                   cfg_idx_i, cfg_wdata_i
// in        in         in_valid_i / in_ready_o    part_present_i, score_valid_i,
//                                                 anomaly_score_i
// out       out        out_valid_o / out_ready_i  phase_o, belt_running_o,
//                                                 reject_arm_out_o, decision_valid_o,
//                                                 part_bad_o, timed_out_o, median_score_o
//
// One tick request per cycle unless the output stalls; each result is registered.
// The sequencer state, median and threshold compare sit between the input register
// and the result register, and state moves only when a request passes into the result.
// Reset is asynchronous, active low, and loads the default register values.
// A stalled output holds one result while a second request waits in the input register.
`default_nettype none

module conveyor_inspection_sequencer import cis_pkg::*; #(
  parameter int TICK_WIDTH  = TICK_WIDTH_DEF,
  parameter int SCORE_WIDTH = SCORE_WIDTH_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [CFG_W-1:0]       cfg_wdata_i,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic                   part_present_i,
  input  wire logic                   score_valid_i,
  input  wire logic [SCORE_WIDTH-1:0] anomaly_score_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic [2:0]                  phase_o,
  output logic                        belt_running_o,
  output logic                        reject_arm_out_o,
  output logic                        decision_valid_o,
  output logic                        part_bad_o,
  output logic                        timed_out_o,
  output logic [SCORE_WIDTH-1:0]      median_score_o
);

  cis_cfg_t               cfg;
  cis_tick_t              tick_in, tick_q;
  logic [SCORE_WIDTH-1:0] score_q;
  logic                   in_valid_q;
  logic                   adv;
  cis_status_t            status_d, status_q;
  logic [SCORE_WIDTH-1:0] median_d, median_q;

  assign tick_in.part_present = part_present_i;
  assign tick_in.score_valid  = score_valid_i;

  // A request moves on when the result register is empty or being drained.
  assign adv = in_valid_q && (!out_valid_o || out_ready_i);

  cis_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .idx_i   (cfg_idx_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  cis_in_reg #(
    .SCORE_WIDTH (SCORE_WIDTH)
  ) u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .tick_i  (tick_in),
    .score_i (anomaly_score_i),
    .adv_i   (adv),
    .valid_o (in_valid_q),
    .tick_o  (tick_q),
    .score_o (score_q)
  );

  cis_seq #(
    .TICK_WIDTH  (TICK_WIDTH),
    .SCORE_WIDTH (SCORE_WIDTH)
  ) u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .cfg_i    (cfg),
    .tick_i   (tick_q),
    .score_i  (score_q),
    .status_o (status_d),
    .median_o (median_d)
  );

  cis_out_reg #(
    .SCORE_WIDTH (SCORE_WIDTH)
  ) u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (adv),
    .status_i (status_d),
    .median_i (median_d),
    .ready_i  (out_ready_i),
    .valid_o  (out_valid_o),
    .status_o (status_q),
    .median_o (median_q)
  );

  assign phase_o          = status_q.phase;
  assign belt_running_o   = status_q.belt_running;
  assign reject_arm_out_o = status_q.reject_arm_out;
  assign decision_valid_o = status_q.decision_valid;
  assign part_bad_o       = status_q.part_bad;
  assign timed_out_o      = status_q.timed_out;
  assign median_score_o   = median_q;

endmodule

`default_nettype wire

// ----- tb/conveyor_inspection_sequencer_tb.sv -----
`default_nettype none

module conveyor_inspection_sequencer_tb import cis_pkg::*; ();

  localparam int SW = SCORE_WIDTH_DEF;
  localparam int TW = TICK_WIDTH_DEF;

  typedef struct packed {
    logic          present;
    logic          svalid;
    logic [SW-1:0] score;
  } sensor_tick_t;

  typedef struct {
    phase_e        phase;
    logic          belt;
    logic          arm;
    logic          decided;
    logic          rejected;
    logic          gave_up;
    logic [SW-1:0] median;
  } status_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = CFG_APPROACH;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic                 part_present_i = 1'b0;
  logic                 score_valid_i = 1'b0;
  logic [SW-1:0]        anomaly_score_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [2:0]           phase_o;
  logic                 belt_running_o;
  logic                 reject_arm_out_o;
  logic                 decision_valid_o;
  logic                 part_bad_o;
  logic                 timed_out_o;
  logic [SW-1:0]        median_score_o;

  conveyor_inspection_sequencer dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .part_present_i   (part_present_i),
    .score_valid_i    (score_valid_i),
    .anomaly_score_i  (anomaly_score_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .phase_o          (phase_o),
    .belt_running_o   (belt_running_o),
    .reject_arm_out_o (reject_arm_out_o),
    .decision_valid_o (decision_valid_o),
    .part_bad_o       (part_bad_o),
    .timed_out_o      (timed_out_o),
    .median_score_o   (median_score_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  sensor_tick_t tick_backlog[$];
  status_t      due_status[$];
  int           ticks_queued = 0;
  int           ticks_accepted = 0;
  int           fault_count = 0;
  int           send_idle_pct = 36;
  int           recv_idle_pct = 65;

  // Mirror of the sequencer registers and state.
  cis_cfg_t      regs_model;
  phase_e        seq_phase;
  logic [TW-1:0] seq_elapsed;
  logic [CNT_W-1:0] seq_count;
  logic [SW-1:0] seq_slot [3];
  logic          seq_bad;
  logic          seq_belt;
  logic          seq_arm;

  function automatic logic coin();
    return 1'($urandom_range(0, 1));
  endfunction

  // Scores cluster around the threshold so that both decisions and the tie occur.
  function automatic logic [SW-1:0] pick_score();
    logic [SW-1:0] thr;
    thr = regs_model.threshold;
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return thr - 1'b1;
      3: return thr;
      4: return thr + 1'b1;
      default: return SW'($urandom);
    endcase
  endfunction

  function automatic logic [SW-1:0] median_of_three(input logic [SW-1:0] a, b, c);
    if ((a <= b && b <= c) || (c <= b && b <= a)) begin
      return b;
    end else if ((b <= a && a <= c) || (c <= a && a <= b)) begin
      return a;
    end
    return c;
  endfunction

  task automatic enter_phase(input phase_e p);
    seq_phase = p;
    seq_elapsed = '0;
  endtask

  task automatic step_sequencer(input logic present, input logic svalid,
                                input logic [SW-1:0] score);
    status_t       r;
    logic [SW-1:0] med;
    r.decided = 1'b0;
    r.rejected = 1'b0;
    r.gave_up = 1'b0;
    r.median = '0;
    if (seq_phase != PH_IDLE && seq_elapsed != '1) seq_elapsed++;
    case (seq_phase)
      PH_IDLE: begin
        if (present) enter_phase(PH_APPROACH);
      end
      PH_APPROACH: begin
        if (seq_elapsed >= regs_model.approach_ticks) begin
          seq_belt = 1'b0;
          seq_count = '0;
          enter_phase(PH_INSPECT);
        end
      end
      PH_INSPECT: begin
        // The timeout wins over a score arriving on the same tick.
        if (seq_elapsed > regs_model.timeout_ticks) begin
          seq_bad = 1'b0;
          seq_belt = 1'b1;
          r.decided = 1'b1;
          r.gave_up = 1'b1;
          enter_phase(PH_RELEASE);
        end else if (svalid) begin
          if (seq_count < CNT_MEDIAN) seq_count++;
          if (seq_count >= CNT_FIRST_KEPT) seq_slot[seq_count - CNT_FIRST_KEPT] = score;
          if (seq_count >= CNT_MEDIAN) begin
            med = median_of_three(seq_slot[0], seq_slot[1], seq_slot[2]);
            seq_bad = (med >= regs_model.threshold);
            if (seq_bad) seq_arm = 1'b1;
            seq_belt = 1'b1;
            r.decided = 1'b1;
            r.rejected = seq_bad;
            r.median = med;
            enter_phase(PH_RELEASE);
          end
        end
      end
      PH_RELEASE: begin
        if (seq_elapsed >= regs_model.release_ticks) begin
          if (seq_bad) seq_arm = 1'b0;
          enter_phase(PH_COOLDOWN);
        end
      end
      default: begin
        if (!present) enter_phase(PH_IDLE);
      end
    endcase
    r.phase = seq_phase;
    r.belt = seq_belt;
    r.arm = seq_arm;
    due_status.push_back(r);
  endtask

  task automatic push_tick(input logic present, input logic svalid,
                           input logic [SW-1:0] score);
    tick_backlog.push_back('{present, svalid, score});
    ticks_queued++;
  endtask

  // One part passing the station, timed from the current register values.
  task automatic push_part();
    int span;
    repeat ($urandom_range(0, 2)) push_tick(1'b0, coin(), pick_score());
    push_tick(1'b1, coin(), pick_score());
    span = (regs_model.approach_ticks == 0) ? 1 : regs_model.approach_ticks;
    repeat (span) push_tick(coin(), coin(), pick_score());
    if ($urandom_range(0, 7) == 0) begin
      span = (regs_model.timeout_ticks < 30) ? regs_model.timeout_ticks + 1 : 30;
      repeat (span) push_tick(coin(), 1'b0, pick_score());
    end
    // Now and then one score short, so the inspection spills into later ticks.
    repeat (($urandom_range(0, 9) == 0) ? 3 : 4) begin
      repeat ($urandom_range(0, 2)) push_tick(coin(), 1'b0, pick_score());
      push_tick(coin(), 1'b1, pick_score());
    end
    span = (regs_model.release_ticks == 0) ? 1 : regs_model.release_ticks;
    repeat (span) push_tick(coin(), coin(), pick_score());
    repeat ($urandom_range(0, 3)) push_tick(1'b1, coin(), pick_score());
    push_tick(1'b0, coin(), pick_score());
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_APPROACH: regs_model.approach_ticks = val;
      CFG_RELEASE:  regs_model.release_ticks = val;
      CFG_TIMEOUT:  regs_model.timeout_ticks = val;
      default:      regs_model.threshold = val;
    endcase
  endtask

  task automatic apply_setting(input logic [CFG_W-1:0] approach, release_t,
                               timeout_t, thr);
    write_reg(CFG_APPROACH, approach);
    write_reg(CFG_RELEASE, release_t);
    write_reg(CFG_TIMEOUT, timeout_t);
    write_reg(CFG_THRESHOLD, thr);
  endtask

  task automatic wait_drained();
    while (ticks_accepted != ticks_queued || due_status.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin : tick_driver
    sensor_tick_t nxt;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        step_sequencer(part_present_i, score_valid_i, anomaly_score_i);
        ticks_accepted++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (tick_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = tick_backlog.pop_front();
          in_valid_i <= 1'b1;
          part_present_i <= nxt.present;
          score_valid_i <= nxt.svalid;
          anomaly_score_i <= nxt.score;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : result_monitor
    status_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (due_status.size() == 0) begin
          fault_count++;
          if (fault_count <= 10) $display("result with no request pending, phase %0d", phase_o);
        end else begin
          want = due_status.pop_front();
          if (want.phase !== phase_o || want.belt !== belt_running_o ||
              want.arm !== reject_arm_out_o || want.decided !== decision_valid_o ||
              want.rejected !== part_bad_o || want.gave_up !== timed_out_o ||
              want.median !== median_score_o) begin
            fault_count++;
            if (fault_count <= 10) begin
              $display("mismatch: expected phase %0d belt %b arm %b dec %b bad %b tmo %b med %h",
                       want.phase, want.belt, want.arm, want.decided, want.rejected,
                       want.gave_up, want.median);
              $display("          actual   phase %0d belt %b arm %b dec %b bad %b tmo %b med %h",
                       phase_o, belt_running_o, reject_arm_out_o, decision_valid_o,
                       part_bad_o, timed_out_o, median_score_o);
            end
          end
        end
      end
      out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  initial begin : stimulus
    int target;
    regs_model.approach_ticks = APPROACH_RST;
    regs_model.release_ticks = RELEASE_RST;
    regs_model.timeout_ticks = TIMEOUT_RST;
    regs_model.threshold = THRESHOLD_RST;
    seq_phase = PH_IDLE;
    seq_elapsed = '0;
    seq_count = '0;
    seq_slot = '{default: '0};
    seq_bad = 1'b0;
    seq_belt = 1'b1;
    seq_arm = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset register values; a score while idle must be ignored.
    push_tick(1'b0, 1'b1, 16'hFFFF);
    push_tick(1'b1, 1'b0, 16'h0000);
    push_tick(1'b0, 1'b1, 16'h1234);
    push_tick(1'b1, 1'b0, 16'h0000);
    wait_drained();

    apply_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);
    push_tick(1'b1, 1'b1, 16'hABCD);
    push_tick(1'b0, 1'b0, 16'h0000);
    wait_drained();

    // Approach shortened while the part is already on its way: the belt stops
    // on the next tick, and the score on that tick is dropped.
    apply_setting(16'd0, 16'd0, 16'd5, 16'hFFFF);
    push_tick(1'b0, 1'b1, 16'h0100);
    push_tick(1'b0, 1'b1, 16'hFFFF);
    push_tick(1'b0, 1'b1, 16'hFFFF);
    push_tick(1'b0, 1'b1, 16'hFFFF);
    push_tick(1'b0, 1'b1, 16'hFFFF);
    push_tick(1'b1, 1'b1, 16'h0005);
    push_tick(1'b1, 1'b0, 16'h0000);
    push_tick(1'b0, 1'b0, 16'h0000);
    // Only three scores before the timeout; the one on the timeout tick is ignored.
    push_tick(1'b1, 1'b0, 16'h0000);
    push_tick(1'b0, 1'b0, 16'h0000);
    push_tick(1'b0, 1'b1, 16'h1234);
    push_tick(1'b0, 1'b1, 16'h0000);
    push_tick(1'b0, 1'b0, 16'h0000);
    push_tick(1'b0, 1'b1, 16'hFFFF);
    push_tick(1'b0, 1'b0, 16'h0000);
    push_tick(1'b0, 1'b1, 16'h8000);
    push_tick(1'b1, 1'b0, 16'h0000);
    push_tick(1'b0, 1'b0, 16'h0000);
    wait_drained();

    for (int seg = 0; seg < 6; seg++) begin
      if (seg == 2) begin
        send_idle_pct = 65;
        recv_idle_pct = 36;
      end else if (seg == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (seg)
        0: apply_setting(16'd1, 16'd2, 16'd12, 16'h0580);
        1: apply_setting(16'd0, 16'd0, 16'd0, 16'h0000);
        2: apply_setting(16'd3, 16'd1, 16'hFFFF, 16'h0000);
        3: apply_setting(16'd2, 16'd3, 16'd8, 16'($urandom));
        4: apply_setting(16'd5, 16'd4, 16'd20, 16'hFFFF);
        default: apply_setting(16'd1, 16'd1, 16'd10, THRESHOLD_RST);
      endcase
      target = ticks_queued + 170;
      while (ticks_queued < target) begin
        if ($urandom_range(0, 6) == 0) begin
          repeat ($urandom_range(1, 8)) push_tick(coin(), coin(), pick_score());
        end else begin
          push_part();
        end
      end
      wait_drained();
    end

    repeat (10) @(posedge clk_i);
    if (fault_count == 0 && due_status.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
+incdir+rtl/core
rtl/core/cis_pkg.sv
rtl/core/cis_cfg.sv
rtl/core/cis_in_reg.sv
rtl/core/cis_seq.sv
rtl/core/cis_out_reg.sv
rtl/core/conveyor_inspection_sequencer.sv
tb/conveyor_inspection_sequencer_tb.sv
